### sv/spq_pkg.sv
// Package with shared constants, codes and handshake types for the sorted priority queue.
`timescale 1ns / 1ps

package spq_pkg;

  // Default sizes of the queue store.
  localparam int unsigned CAPACITY       = 16;
  localparam int unsigned PRIORITY_WIDTH = 32;
  localparam int unsigned TAG_WIDTH      = 32;

  // Widths of the stream and configuration payloads.
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned IN_USER_W  = 1;
  localparam int unsigned OUT_DATA_W = 80;

  // Widths of the result fields on the output stream.
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned FIELD_W    = 32;
  localparam int unsigned COUNT_W    = 5;
  localparam int unsigned OUT_PAD_W  = OUT_DATA_W - STATUS_W - 2 * FIELD_W - 1 - COUNT_W;

  // Operation carried in the input tuser.
  typedef enum logic [0:0] {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_NULL_TAG = 3'd1,
    ST_BAD_MODE = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_FULL     = 3'd4
  } status_e;

  // Controller states.
  typedef enum logic [1:0] {
    CS_IDLE,
    CS_DECIDE,
    CS_SWEEP,
    CS_FINISH
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic decide;
    logic sweep;
    logic finish;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic reject;
    logic sweep_done;
    logic out_busy;
  } ctrl_sts_t;

endpackage

### sv/spq_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module spq_ram #(
  parameter  int unsigned WIDTH = 8,
  parameter  int unsigned DEPTH = 16,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; a read returns the contents before a same-cycle write.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/spq_ctrl.sv
// Controller state machine that sequences one queue operation at a time.
`timescale 1ns / 1ps

module spq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  spq_pkg::ctrl_sts_t sts_i,
  output spq_pkg::ctrl_cmd_t cmd_o
);

  spq_pkg::ctrl_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= spq_pkg::CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      spq_pkg::CS_IDLE: begin
        if (in_valid_i) begin
          state_d = spq_pkg::CS_DECIDE;
        end
      end
      spq_pkg::CS_DECIDE: begin
        state_d = sts_i.reject ? spq_pkg::CS_FINISH : spq_pkg::CS_SWEEP;
      end
      spq_pkg::CS_SWEEP: begin
        if (sts_i.sweep_done) begin
          state_d = spq_pkg::CS_FINISH;
        end
      end
      spq_pkg::CS_FINISH: begin
        if (!sts_i.out_busy) begin
          state_d = spq_pkg::CS_IDLE;
        end
      end
      default: state_d = spq_pkg::CS_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    unique case (state_q)
      spq_pkg::CS_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      spq_pkg::CS_DECIDE: begin
        cmd_o.decide = 1'b1;
      end
      spq_pkg::CS_SWEEP: begin
        cmd_o.sweep = 1'b1;
      end
      spq_pkg::CS_FINISH: begin
        cmd_o.finish = !sts_i.out_busy;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

### sv/spq_datapath.sv
// Datapath: order register, slot RAM sweep for insert and remove, and the result register.
`timescale 1ns / 1ps

module spq_datapath #(
  parameter int unsigned CAPACITY       = spq_pkg::CAPACITY,
  parameter int unsigned PRIORITY_WIDTH = spq_pkg::PRIORITY_WIDTH,
  parameter int unsigned TAG_WIDTH      = spq_pkg::TAG_WIDTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic [spq_pkg::MODE_W-1:0]     cfg_data_i,
  input  logic [spq_pkg::IN_DATA_W-1:0]  in_data_i,
  input  logic [spq_pkg::IN_USER_W-1:0]  in_user_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [spq_pkg::OUT_DATA_W-1:0] out_data_o,
  input  spq_pkg::ctrl_cmd_t             cmd_i,
  output spq_pkg::ctrl_sts_t             sts_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = PRIORITY_WIDTH;
  localparam int unsigned TW = TAG_WIDTH;
  localparam int unsigned EW = TW + PW;
  localparam int unsigned FW = spq_pkg::FIELD_W;

  // Control registers.
  logic [spq_pkg::MODE_W-1:0] mode_q;
  spq_pkg::op_e               op_q;
  logic                       found_q;
  logic [CW-1:0]              count_q;
  logic [CW-1:0]              last_q;
  logic [CW-1:0]              idx_q;
  logic                       proc_valid_q;
  logic [CW-1:0]              proc_idx_q;
  spq_pkg::status_e           status_q;
  logic                       out_valid_q;

  // Payload registers.
  logic [EW-1:0]                 carry_q;
  logic [TW-1:0]                 removed_q;
  logic signed [PW-1:0]          head_prio_q;
  logic [spq_pkg::OUT_DATA_W-1:0] out_data_q;

  // Input decode.
  logic [TW-1:0]        in_tag;
  logic signed [FW-1:0] in_prio_raw;
  logic signed [PW-1:0] in_prio;

  assign in_tag      = TW'(in_data_i[FW-1:0]);
  assign in_prio_raw = in_data_i[2*FW-1:FW];
  assign in_prio     = PW'(in_prio_raw);

  // Classification of the held operation.
  logic             mode_bad;
  logic             ascending;
  spq_pkg::status_e step_status;

  assign mode_bad  = (mode_q == '0);
  assign ascending = mode_q[1];

  always_comb begin
    if (op_q == spq_pkg::OP_INSERT) begin
      priority if (carry_q[EW-1:PW] == '0) begin
        step_status = spq_pkg::ST_NULL_TAG;
      end else if (mode_bad) begin
        step_status = spq_pkg::ST_BAD_MODE;
      end else if (count_q >= CW'(CAPACITY)) begin
        step_status = spq_pkg::ST_FULL;
      end else begin
        step_status = spq_pkg::ST_OK;
      end
    end else begin
      priority if (mode_bad) begin
        step_status = spq_pkg::ST_BAD_MODE;
      end else if (count_q == '0) begin
        step_status = spq_pkg::ST_EMPTY;
      end else begin
        step_status = spq_pkg::ST_OK;
      end
    end
  end

  // Sweep read issue: one slot per cycle, from slot zero to the last slot.
  logic issue;
  assign issue = cmd_i.sweep && (idx_q <= last_q);

  // Slot RAM holding {tag, priority} per entry.
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic [EW-1:0] ram_rdata;

  spq_ram #(
    .WIDTH (EW),
    .DEPTH (CAPACITY)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (issue),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Processing of the slot read in the previous cycle.
  logic [TW-1:0]        rd_tag;
  logic signed [PW-1:0] rd_prio;
  logic signed [PW-1:0] new_prio;
  logic                 worse_or_equal;
  logic                 at_end;
  logic                 ins_write;
  logic                 rem_write;
  logic [CW-1:0]        proc_idx_dec;

  assign rd_tag       = ram_rdata[EW-1:PW];
  assign rd_prio      = ram_rdata[PW-1:0];
  assign new_prio     = carry_q[PW-1:0];
  assign at_end       = (proc_idx_q == count_q);
  assign proc_idx_dec = proc_idx_q - 1'b1;

  // The new entry goes before the first entry whose priority is equal or worse.
  assign worse_or_equal = ascending ? (rd_prio >= new_prio) : (rd_prio <= new_prio);

  // Insert writes the carried entry from the hit onward; remove moves entries down by one.
  assign ins_write = proc_valid_q && (op_q == spq_pkg::OP_INSERT) &&
                     (found_q || at_end || worse_or_equal);
  assign rem_write = proc_valid_q && (op_q == spq_pkg::OP_REMOVE) && (proc_idx_q != '0);

  assign ram_we    = ins_write || rem_write;
  assign ram_waddr = ins_write ? proc_idx_q[AW-1:0] : proc_idx_dec[AW-1:0];
  assign ram_wdata = ins_write ? carry_q : ram_rdata;

  // Result of the finished operation.
  logic [CW-1:0] count_next;
  logic          head_ok;
  logic          out_busy;

  always_comb begin
    count_next = count_q;
    if (status_q == spq_pkg::ST_OK) begin
      count_next = (op_q == spq_pkg::OP_INSERT) ? count_q + 1'b1 : count_q - 1'b1;
    end
  end

  assign head_ok  = !mode_bad && (count_next != '0);
  assign out_busy = out_valid_q && !out_ready_i;

  assign sts_o.reject     = (step_status != spq_pkg::ST_OK);
  assign sts_o.sweep_done = proc_valid_q && (proc_idx_q == last_q);
  assign sts_o.out_busy   = out_busy;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= spq_pkg::MODE_W'(1);
      op_q         <= spq_pkg::OP_INSERT;
      found_q      <= 1'b0;
      count_q      <= '0;
      last_q       <= '0;
      idx_q        <= '0;
      proc_valid_q <= 1'b0;
      proc_idx_q   <= '0;
      status_q     <= spq_pkg::ST_OK;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        mode_q <= cfg_data_i;
      end
      if (cmd_i.accept) begin
        op_q    <= spq_pkg::op_e'(in_user_i[0]);
        found_q <= 1'b0;
        idx_q   <= '0;
      end
      if (cmd_i.decide) begin
        status_q <= step_status;
        last_q   <= (op_q == spq_pkg::OP_INSERT) ? count_q : count_q - 1'b1;
      end
      if (issue) begin
        idx_q <= idx_q + 1'b1;
      end
      proc_valid_q <= issue;
      proc_idx_q   <= idx_q;
      if (ins_write && !at_end) begin
        found_q <= 1'b1;
      end
      if (cmd_i.finish) begin
        count_q     <= count_next;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      carry_q   <= {in_tag, in_prio};
      removed_q <= '0;
    end
    if (ins_write && !at_end) begin
      carry_q <= ram_rdata;
    end
    if (ins_write && (proc_idx_q == '0)) begin
      head_prio_q <= new_prio;
    end
    if (proc_valid_q && (op_q == spq_pkg::OP_REMOVE) && (proc_idx_q == '0)) begin
      removed_q <= rd_tag;
    end
    if (rem_write && (proc_idx_q == CW'(1))) begin
      head_prio_q <= rd_prio;
    end
    if (cmd_i.finish) begin
      out_data_q <= {{spq_pkg::OUT_PAD_W{1'b0}},
                     spq_pkg::COUNT_W'(count_next),
                     head_ok,
                     head_ok ? FW'(head_prio_q) : {FW{1'b0}},
                     FW'(removed_q),
                     status_q};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // The store never holds more entries than its capacity.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count exceeds capacity");

  // A new operation starts its sweep from slot zero with nothing carried past a hit.
  a_accept_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.accept |=> (idx_q == '0) && !found_q)
    else $error("sweep not restarted on a new operation");

  // Only operations that passed their checks sweep the slot RAM.
  a_sweep_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_o.sweep_done |-> (status_q == spq_pkg::ST_OK))
    else $error("slot sweep for a rejected operation");

  // An insert sweep never processes a slot beyond the current fill.
  a_insert_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc_valid_q && (op_q == spq_pkg::OP_INSERT)) |-> (proc_idx_q <= count_q))
    else $error("insert sweep past the held entries");

endmodule

### sv/sorted_priority_queue.sv
// Top level of the sorted priority queue: controller, datapath and port wiring.
//
// Usage:
//   The input stream carries one operation per transfer. tuser selects the operation
//   (0 insert, 1 remove head); tdata holds the tag and the Q16.16 priority to insert.
//   Every operation yields exactly one result transfer on the output stream with the
//   status, the removed tag, the head priority and valid flag, and the entry count.
//   The configuration channel writes the order mode (negative: smallest first,
//   positive: largest first, zero: queue invalid); write it only while the queue is idle.
//   Sequencing: one operation is in flight at a time. A rejected operation skips the
//   slot RAM sweep; an accepted insert or remove sweeps the slot RAM one entry per
//   cycle through its single read port, moving entries up or down by one.
//   Reset empties the queue and sets the mode to largest first; the slot RAM is not
//   cleared, since only entries below the count are ever used.
//   A stalled receiver holds the result in the output register; the next operation is
//   accepted and worked on, and waits only to hand its own result over.
`timescale 1ns / 1ps

module sorted_priority_queue #(
  parameter int unsigned CAPACITY       = spq_pkg::CAPACITY,
  parameter int unsigned PRIORITY_WIDTH = spq_pkg::PRIORITY_WIDTH,
  parameter int unsigned TAG_WIDTH      = spq_pkg::TAG_WIDTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write channel: order_mode in bits [1:0].
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [spq_pkg::MODE_W-1:0]     cfg_data_i,
  // Input stream.
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // tdata: object_tag [31:0], priority_req [63:32].
  input  logic [spq_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  // tuser: op [0].
  input  logic [spq_pkg::IN_USER_W-1:0]  s_axis_tuser_i,
  // Output stream.
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // tdata: status [2:0], removed_tag [34:3], head_priority [66:35], head_valid [67],
  //        count [72:68], zero fill [79:73].
  output logic [spq_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);

  spq_pkg::ctrl_cmd_t cmd;
  spq_pkg::ctrl_sts_t sts;

  // The mode register takes a write in any cycle.
  assign cfg_ready_o = 1'b1;

  // Operation sequencing.
  spq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Storage, compare and result datapath.
  spq_datapath #(
    .CAPACITY       (CAPACITY),
    .PRIORITY_WIDTH (PRIORITY_WIDTH),
    .TAG_WIDTH      (TAG_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata_i),
    .in_user_i   (s_axis_tuser_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

### tb/tb_sorted_priority_queue.sv
// Self-checking testbench for the sorted priority queue, driven by directed and randomized stream traffic.
`timescale 1ns / 1ps

module tb_sorted_priority_queue;
  import spq_pkg::*;

  localparam int CLK_PERIOD    = 8;
  localparam int SETTLE_CYCLES = 8;
  localparam int END_CYCLES    = 40;

  // Order mode register values.
  localparam logic [MODE_W-1:0] MODE_INVALID       = 2'b00;
  localparam logic [MODE_W-1:0] MODE_MAX_FIRST     = 2'b01;
  localparam logic [MODE_W-1:0] MODE_MIN_FIRST_ALT = 2'b10;
  localparam logic [MODE_W-1:0] MODE_MIN_FIRST     = 2'b11;

  // Kinds of pending stimulus steps.
  typedef enum logic [1:0] {
    STEP_OP,
    STEP_MODE,
    STEP_DRAIN
  } step_kind_e;

  typedef struct {
    step_kind_e            kind;
    op_e                   op;
    logic [TAG_WIDTH-1:0]  tag;
    logic [FIELD_W-1:0]    prio;
    logic [MODE_W-1:0]     mode;
  } step_t;

  // One result as carried on the output stream, first member in the highest bits.
  typedef struct packed {
    status_e              status;
    logic [FIELD_W-1:0]   removed_tag;
    logic [FIELD_W-1:0]   head_prio;
    logic                 head_valid;
    logic [COUNT_W-1:0]   count;
  } result_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [MODE_W-1:0]     cfg_data  = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata   = '0;
  logic [IN_USER_W-1:0]  s_tuser   = '0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  sorted_priority_queue DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Shadow copy of the queue contents and the order mode.
  logic signed [PRIORITY_WIDTH-1:0] slot_prio [CAPACITY];
  logic [TAG_WIDTH-1:0]             slot_tag  [CAPACITY];
  int                               held       = 0;
  logic [MODE_W-1:0]                order_mode = MODE_MAX_FIRST;

  step_t       pending[$];
  result_t     expected_q[$];
  int unsigned issued_cnt  = 0;
  int unsigned retired_cnt = 0;
  int          fail_cnt    = 0;
  int          send_gap    = 0;
  int          send_burst  = 0;
  int          recv_stall  = 0;
  int          recv_burst  = 0;
  int          quiet       = 0;

  // Applies one queue operation to the shadow copy and returns the result it yields.
  function automatic result_t apply_queue_op(op_e op, logic [TAG_WIDTH-1:0] tag,
                                             logic signed [FIELD_W-1:0] prio);
    result_t r;
    logic    ascending;
    logic    invalid;
    int      pos;
    ascending     = order_mode[1];
    invalid       = (order_mode == MODE_INVALID);
    r.status      = ST_OK;
    r.removed_tag = '0;
    r.head_prio   = '0;
    r.head_valid  = 1'b0;
    if (op == OP_INSERT) begin
      if (tag == '0) begin
        r.status = ST_NULL_TAG;
      end else if (invalid) begin
        r.status = ST_BAD_MODE;
      end else if (held >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        // The new entry goes ahead of the first entry with equal or worse priority.
        pos = held;
        for (int i = 0; i < held; i++) begin
          if (pos == held && (ascending ? (slot_prio[i] >= prio) : (slot_prio[i] <= prio)))
            pos = i;
        end
        for (int i = held; i > pos; i--) begin
          slot_prio[i] = slot_prio[i-1];
          slot_tag[i]  = slot_tag[i-1];
        end
        slot_prio[pos] = prio;
        slot_tag[pos]  = tag;
        held++;
      end
    end else begin
      if (invalid) begin
        r.status = ST_BAD_MODE;
      end else if (held == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.removed_tag = slot_tag[0];
        for (int i = 0; i < held - 1; i++) begin
          slot_prio[i] = slot_prio[i+1];
          slot_tag[i]  = slot_tag[i+1];
        end
        held--;
      end
    end
    if (!invalid && held > 0) begin
      r.head_valid = 1'b1;
      r.head_prio  = slot_prio[0];
    end
    r.count = COUNT_W'(held);
    return r;
  endfunction

  // Length of the next idle stretch: mostly short, a few long, sometimes a run with none.
  function automatic int idle_length(inout int burst_left);
    int roll;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      burst_left = $urandom_range(10, 40);
      return 0;
    end
    if (roll < 40) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Priorities: extremes, a narrow band that produces ties, or anything.
  function automatic logic [FIELD_W-1:0] pick_prio();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3, 4: return (32'($urandom_range(0, 6)) - 32'd3) << 16;
      default: return $urandom();
    endcase
  endfunction

  function automatic void queue_step(step_kind_e kind, op_e op, logic [TAG_WIDTH-1:0] tag,
                                     logic [FIELD_W-1:0] prio, logic [MODE_W-1:0] mode);
    step_t s;
    s.kind = kind;
    s.op   = op;
    s.tag  = tag;
    s.prio = prio;
    s.mode = mode;
    pending.push_back(s);
  endfunction

  // A random phase under one mode: inserts dominate in one half and removes in the
  // other, so the queue swings between full and empty. It pauses midway until idle.
  function automatic void add_phase(logic [MODE_W-1:0] mode, int n, int insert_pct);
    int                   share;
    int                   roll;
    logic [TAG_WIDTH-1:0] tag;
    queue_step(STEP_MODE, OP_INSERT, '0, '0, mode);
    for (int k = 0; k < n; k++) begin
      if (k == n / 2)
        queue_step(STEP_DRAIN, OP_INSERT, '0, '0, '0);
      share = (k < n / 2) ? insert_pct : 100 - insert_pct;
      roll  = $urandom_range(0, 99);
      if (roll < 6)
        tag = '0;
      else if (roll < 10)
        tag = '1;
      else
        tag = $urandom();
      queue_step(STEP_OP, ($urandom_range(0, 99) < share) ? OP_INSERT : OP_REMOVE, tag,
                 pick_prio(), '0);
    end
  endfunction

  // Driver: feeds pending steps to the input stream and the mode channel, and
  // predicts the result of every accepted input transfer.
  always @(posedge clk) begin
    step_t                nxt_step;
    logic                 nxt_s_valid;
    logic                 nxt_cfg_valid;
    logic [IN_DATA_W-1:0] nxt_data;
    logic [IN_USER_W-1:0] nxt_user;
    logic [MODE_W-1:0]    nxt_mode;
    nxt_s_valid   = s_tvalid;
    nxt_cfg_valid = cfg_valid;
    nxt_data      = s_tdata;
    nxt_user      = s_tuser;
    nxt_mode      = cfg_data;
    if (rst_n) begin
      if (s_tvalid && s_tready) begin
        expected_q.push_back(apply_queue_op(op_e'(s_tuser), s_tdata[31:0], s_tdata[63:32]));
        issued_cnt  <= issued_cnt + 1;
        nxt_s_valid  = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        order_mode    = cfg_data;
        nxt_cfg_valid = 1'b0;
      end

      // Count idle cycles with no result outstanding; mode writes wait for a few.
      if (issued_cnt == retired_cnt && !s_tvalid && !cfg_valid)
        quiet = (quiet < 1000) ? quiet + 1 : quiet;
      else
        quiet = 0;

      if (!nxt_s_valid && !nxt_cfg_valid && pending.size() > 0) begin
        if (send_gap > 0) begin
          send_gap--;
        end else begin
          nxt_step = pending[0];
          case (nxt_step.kind)
            STEP_OP: begin
              void'(pending.pop_front());
              nxt_s_valid = 1'b1;
              nxt_data    = {nxt_step.prio, nxt_step.tag};
              nxt_user    = nxt_step.op;
              send_gap    = idle_length(send_burst);
            end
            STEP_MODE: begin
              if (quiet >= SETTLE_CYCLES) begin
                void'(pending.pop_front());
                nxt_cfg_valid = 1'b1;
                nxt_mode      = nxt_step.mode;
              end
            end
            default: begin
              if (quiet >= SETTLE_CYCLES)
                void'(pending.pop_front());
            end
          endcase
        end
      end
    end
    s_tvalid  <= nxt_s_valid;
    s_tdata   <= nxt_data;
    s_tuser   <= nxt_user;
    cfg_valid <= nxt_cfg_valid;
    cfg_data  <= nxt_mode;
  end

  // Monitor: checks each result transfer against the oldest prediction and
  // stalls the output stream at random while a result is waiting.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    logic    nxt_ready;
    nxt_ready = 1'b0;
    if (rst_n) begin
      if (m_tvalid && m_tready) begin
        got = result_t'({m_tdata[2:0], m_tdata[34:3], m_tdata[66:35], m_tdata[67],
                         m_tdata[72:68]});
        retired_cnt <= retired_cnt + 1;
        if (expected_q.size() == 0) begin
          fail_cnt++;
          $display("%0t: result with none expected: status %0d tag %h prio %h valid %0d count %0d",
                   $time, got.status, got.removed_tag, got.head_prio, got.head_valid,
                   got.count);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            fail_cnt++;
            $display({"%0t: mismatch: expected status %0d tag %h prio %h valid %0d count %0d,",
                      " got status %0d tag %h prio %h valid %0d count %0d"},
                     $time, want.status, want.removed_tag, want.head_prio, want.head_valid,
                     want.count, got.status, got.removed_tag, got.head_prio,
                     got.head_valid, got.count);
          end
        end
        recv_stall = idle_length(recv_burst);
      end else if (m_tvalid && recv_stall > 0) begin
        recv_stall--;
      end
      nxt_ready = (recv_stall == 0);
    end
    m_tready <= nxt_ready;
  end

  // Stimulus, reset and end of run.
  initial begin
    // Directed: empty remove, null tag, extreme tags and priorities, equal priorities.
    queue_step(STEP_OP, OP_REMOVE, '0, '0, '0);
    queue_step(STEP_OP, OP_INSERT, '0, 32'h0001_0000, '0);
    queue_step(STEP_OP, OP_INSERT, 32'hFFFF_FFFF, 32'h7FFF_FFFF, '0);
    queue_step(STEP_OP, OP_INSERT, 32'h0000_0001, 32'h8000_0000, '0);
    queue_step(STEP_OP, OP_INSERT, 32'h0000_0002, 32'h0000_0000, '0);
    queue_step(STEP_OP, OP_INSERT, 32'h0000_0003, 32'h0000_0000, '0);
    queue_step(STEP_OP, OP_INSERT, 32'h8000_0000, 32'hFFFF_FFFF, '0);
    queue_step(STEP_OP, OP_REMOVE, '1, '1, '0);
    queue_step(STEP_OP, OP_REMOVE, '0, '0, '0);
    // Fill to capacity, then an insert into a full queue and a null tag on a full queue.
    for (int i = 0; i < 13; i++)
      queue_step(STEP_OP, OP_INSERT, 32'h0000_0100 + i, pick_prio(), '0);
    queue_step(STEP_OP, OP_INSERT, 32'h5A5A_A5A5, 32'h0002_0000, '0);
    queue_step(STEP_OP, OP_INSERT, '0, 32'h0002_0000, '0);
    // Invalid mode with entries held.
    queue_step(STEP_MODE, OP_INSERT, '0, '0, MODE_INVALID);
    queue_step(STEP_OP, OP_INSERT, 32'h0000_0005, 32'h0003_0000, '0);
    queue_step(STEP_OP, OP_REMOVE, '0, '0, '0);
    queue_step(STEP_OP, OP_INSERT, '0, 32'h0003_0000, '0);

    // Random phases; each mode change keeps the stored order as it is.
    add_phase(MODE_MIN_FIRST, 120, 75);
    add_phase(MODE_MAX_FIRST, 120, 70);
    add_phase(MODE_MIN_FIRST_ALT, 100, 80);
    add_phase(MODE_INVALID, 30, 50);
    add_phase(MODE_MIN_FIRST, 120, 35);
    add_phase(MODE_MAX_FIRST, 120, 75);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (pending.size() != 0 || s_tvalid || cfg_valid || issued_cnt != retired_cnt)
      @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);

    if (fail_cnt == 0 && expected_q.size() == 0)
      $display("tb_sorted_priority_queue passed");
    else
      $display("tb_sorted_priority_queue failed");
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #5_000_000;
    $display("tb_sorted_priority_queue failed");
    $finish;
  end

endmodule
